// ===== design/fpsa_pkg.sv =====
package fpsa_pkg;

	localparam int unsigned ADDR_W     = 64;
	localparam int unsigned PAGE_BYTES = 4096;
	localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int unsigned PN_W       = ADDR_W - PAGE_SHIFT;
	localparam int unsigned MAX_PAGES  = 65536;
	localparam int unsigned IDX_W      = $clog2(MAX_PAGES);
	localparam int unsigned CNT_W      = IDX_W + 1;
	localparam int unsigned PADDR_W    = 4;

	typedef enum logic [1:0] {
		ACT_FREE  = 2'd0,
		ACT_ALLOC = 2'd1,
		ACT_RANGE = 2'd2,
		ACT_RSVD  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_EMPTY   = 2'd1,
		STAT_INVALID = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	typedef enum logic {
		REG_LOW  = 1'b0,
		REG_HIGH = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_RANGE,
		S_CHECK,
		S_INDEX,
		S_POP
	} state_t;

endpackage

// ===== design/free_page_stack_allocator.sv =====
// Free page stack allocator, LIFO of page indices in a single-port-write stack RAM.
// Steps to done strobe: allocate runs dispatch, pop (dispatch alone on an empty stack); single
// free runs dispatch, valid, index (ends at valid when invalid); range free runs dispatch, then
// range, valid, index per page pushed, stopping at valid on an invalid page, at index when full.
// Throughput: one transaction at a time; busy drops with done, next start taken at its end.
// Async reset clears the limits, the stack count and the sequencer; stack RAM is not cleared.
module free_page_stack_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    action,
	input  logic [fpsa_pkg::ADDR_W-1:0]   address,
	input  logic [fpsa_pkg::ADDR_W-1:0]   range_end,
	output logic                          done,
	output logic [fpsa_pkg::ADDR_W-1:0]   page_address,
	output logic [1:0]                    status,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fpsa_pkg::PADDR_W-1:0]  paddr,
	input  logic [fpsa_pkg::ADDR_W-1:0]   pwdata,
	output logic [fpsa_pkg::ADDR_W-1:0]   prdata,
	output logic                          pready
);
	import fpsa_pkg::*;

	state_t state_q, state_d;

	logic [ADDR_W-1:0] low_limit_q, high_limit_q;
	logic [PN_W-1:0]   base_pn_q;
	logic [ADDR_W-1:0] p_q;
	logic [ADDR_W-1:0] end_q;
	action_t           act_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  rd_q;
	logic [IDX_W-1:0]  stack_mem [MAX_PAGES];

	logic              done_q;
	logic [ADDR_W-1:0] page_q;
	status_t           stat_q;

	logic              accept, cfg_wr;
	logic [PN_W-1:0]   addr_pn_rnd, idx_diff;
	logic              rnd_ovf, p_in_range, page_ok, idx_ok, stack_full, p_last;

	logic              fin;
	status_t           fin_st;
	logic [ADDR_W-1:0] fin_page;
	logic              push, pop, p_round, p_inc;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (reg_idx_t'(paddr[PADDR_W-1]) == REG_HIGH) ? high_limit_q : low_limit_q;

	assign done         = done_q;
	assign page_address = page_q;
	assign status       = stat_q;

	// range start rounded up to a page boundary
	assign addr_pn_rnd = p_q[ADDR_W-1:PAGE_SHIFT] + PN_W'(p_q[PAGE_SHIFT-1:0] != '0);
	assign rnd_ovf     = (&p_q[ADDR_W-1:PAGE_SHIFT]) && (p_q[PAGE_SHIFT-1:0] != '0);
	assign p_in_range  = p_q[ADDR_W-1:PAGE_SHIFT] < end_q[ADDR_W-1:PAGE_SHIFT];
	// aligned and >= low implies >= base
	assign page_ok     = (p_q[PAGE_SHIFT-1:0] == '0) && (p_q >= low_limit_q)
	                     && (p_q < high_limit_q);
	assign idx_diff    = p_q[ADDR_W-1:PAGE_SHIFT] - base_pn_q;
	assign idx_ok      = idx_diff < PN_W'(MAX_PAGES);
	assign stack_full  = count_q == CNT_W'(MAX_PAGES);
	assign p_last      = &p_q[ADDR_W-1:PAGE_SHIFT];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept)
					state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				unique case (act_q)
					ACT_FREE:  state_d = S_CHECK;
					ACT_ALLOC: state_d = (count_q == '0) ? S_IDLE : S_POP;
					ACT_RANGE: state_d = (rnd_ovf || end_q[ADDR_W-1:PAGE_SHIFT] == '0)
					                     ? S_IDLE : S_RANGE;
					ACT_RSVD:  state_d = S_IDLE;
					default:   state_d = S_IDLE;
				endcase
			end
			S_RANGE: state_d = p_in_range ? S_CHECK : S_IDLE;
			S_CHECK: state_d = page_ok ? S_INDEX : S_IDLE;
			S_INDEX: begin
				if (!idx_ok || stack_full || act_q != ACT_RANGE || p_last)
					state_d = S_IDLE;
				else
					state_d = S_RANGE;
			end
			S_POP:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		fin      = 1'b0;
		fin_st   = STAT_OK;
		fin_page = '0;
		push     = 1'b0;
		pop      = 1'b0;
		p_round  = 1'b0;
		p_inc    = 1'b0;
		unique case (state_q)
			S_IDLE: ;
			S_DISPATCH: begin
				unique case (act_q)
					ACT_FREE: ;
					ACT_ALLOC: begin
						if (count_q == '0) begin
							fin    = 1'b1;
							fin_st = STAT_EMPTY;
						end else begin
							pop = 1'b1;
						end
					end
					ACT_RANGE: begin
						if (rnd_ovf || end_q[ADDR_W-1:PAGE_SHIFT] == '0)
							fin = 1'b1;
						else
							p_round = 1'b1;
					end
					ACT_RSVD: begin
						fin    = 1'b1;
						fin_st = STAT_INVALID;
					end
					default: ;
				endcase
			end
			S_RANGE: fin = !p_in_range;
			S_CHECK: begin
				if (!page_ok) begin
					fin    = 1'b1;
					fin_st = STAT_INVALID;
				end
			end
			S_INDEX: begin
				if (!idx_ok || stack_full) begin
					fin    = 1'b1;
					fin_st = STAT_FULL;
				end else begin
					push = 1'b1;
					if (act_q != ACT_RANGE || p_last)
						fin = 1'b1;
					else
						p_inc = 1'b1;
				end
			end
			S_POP: begin
				fin      = 1'b1;
				fin_page = {base_pn_q + PN_W'(rd_q), {PAGE_SHIFT{1'b0}}};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			low_limit_q  <= '0;
			high_limit_q <= '0;
			count_q      <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (cfg_wr) begin
				if (reg_idx_t'(paddr[PADDR_W-1]) == REG_HIGH)
					high_limit_q <= pwdata;
				else
					low_limit_q <= pwdata;
			end
			if (push)
				count_q <= count_q + 1'b1;
			else if (pop)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		base_pn_q <= low_limit_q[ADDR_W-1:PAGE_SHIFT]
		             + PN_W'(low_limit_q[PAGE_SHIFT-1:0] != '0);
		if (accept) begin
			p_q   <= address;
			end_q <= range_end;
			act_q <= action_t'(action);
		end else if (p_round) begin
			p_q <= {addr_pn_rnd, {PAGE_SHIFT{1'b0}}};
		end else if (p_inc) begin
			p_q <= {p_q[ADDR_W-1:PAGE_SHIFT] + 1'b1, {PAGE_SHIFT{1'b0}}};
		end
		if (fin) begin
			page_q <= fin_page;
			stat_q <= fin_st;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			stack_mem[count_q[IDX_W-1:0]] <= idx_diff[IDX_W-1:0];
		rd_q <= stack_mem[IDX_W'(count_q - 1'b1)];
	end

endmodule

// ===== design/fpsa_checker.sv =====
module fpsa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [fpsa_pkg::ADDR_W-1:0]   page_address,
	input logic [1:0]                    status
);
	import fpsa_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result issued while still busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != STAT_OK |-> page_address == '0)
		else $error("failed transaction returned an address");

endmodule

bind free_page_stack_allocator fpsa_checker u_fpsa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.page_address (page_address),
	.status       (status)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	import fpsa_pkg::*;

	localparam logic [ADDR_W-1:0] ADDR_MAX  = '1;
	localparam logic [ADDR_W-1:0] PAGE_SZ   = ADDR_W'(PAGE_BYTES);
	localparam logic [ADDR_W-1:0] TOP_PAGE  = ADDR_MAX - PAGE_SZ + 1;
	localparam logic [ADDR_W-1:0] A_LOW     = 64'h0000_0000_0000_1001;
	localparam logic [ADDR_W-1:0] A_BASE    = 64'h0000_0000_0000_2000;
	localparam logic [ADDR_W-1:0] A_HIGH    = A_BASE + 40 * PAGE_SZ;
	localparam logic [ADDR_W-1:0] FILL_LOW  = 64'h0000_0000_0001_0800;
	localparam logic [ADDR_W-1:0] FILL_BASE = 64'h0000_0000_0001_1000;
	localparam int unsigned       RUN_LIMIT = 2_000_000;

	typedef struct packed {
		logic [ADDR_W-1:0] page;
		status_t           stat;
	} outcome_t;

	class page_stack_tracker;
		logic [ADDR_W-1:0] low_lim;
		logic [ADDR_W-1:0] high_lim;
		logic [IDX_W-1:0]  stack_mem [MAX_PAGES];
		int unsigned       depth;
		int unsigned       peak_depth;
		outcome_t          pending [$];
		int unsigned       mismatches;
		int unsigned       checked;
		int unsigned       stat_seen [4];

		function new();
			low_lim    = '0;
			high_lim   = '0;
			depth      = 0;
			peak_depth = 0;
			mismatches = 0;
			checked    = 0;
			foreach (stat_seen[i]) stat_seen[i] = 0;
		endfunction

		// r is left at zero when v cannot be rounded up within 64 bits
		function bit align_up(input logic [ADDR_W-1:0] v, output logic [ADDR_W-1:0] r);
			logic [ADDR_W-1:0] rem;
			r   = '0;
			rem = v % PAGE_SZ;
			if (rem == 0) begin
				r = v;
				return 1'b1;
			end
			if (v > ADDR_MAX - (PAGE_SZ - rem)) return 1'b0;
			r = v + (PAGE_SZ - rem);
			return 1'b1;
		endfunction

		function void set_limit(input reg_idx_t r, input logic [ADDR_W-1:0] val);
			if (r == REG_LOW) low_lim = val;
			else high_lim = val;
		endfunction

		function status_t push_page(input logic [ADDR_W-1:0] a);
			logic [ADDR_W-1:0] base;
			logic [ADDR_W-1:0] idx;
			if (a % PAGE_SZ != 0 || a < low_lim || a >= high_lim) return STAT_INVALID;
			if (!align_up(low_lim, base) || a < base) return STAT_INVALID;
			idx = (a - base) / PAGE_SZ;
			if (idx >= MAX_PAGES || depth >= MAX_PAGES) return STAT_FULL;
			stack_mem[depth] = idx[IDX_W-1:0];
			depth++;
			if (depth > peak_depth) peak_depth = depth;
			return STAT_OK;
		endfunction

		function void note_request(input action_t act, input logic [ADDR_W-1:0] addr,
				input logic [ADDR_W-1:0] rend);
			outcome_t          o;
			logic [ADDR_W-1:0] p;
			logic [ADDR_W-1:0] base;
			o.page = '0;
			o.stat = STAT_OK;
			case (act)
				ACT_FREE: o.stat = push_page(addr);
				ACT_ALLOC: begin
					if (depth == 0) begin
						o.stat = STAT_EMPTY;
					end else begin
						depth--;
						void'(align_up(low_lim, base));
						o.page = base + ADDR_W'(stack_mem[depth]) * PAGE_SZ;
					end
				end
				ACT_RANGE: begin
					if (align_up(addr, p) && rend >= PAGE_SZ) begin
						while (p <= rend - PAGE_SZ) begin
							o.stat = push_page(p);
							if (o.stat != STAT_OK) break;
							if (p > ADDR_MAX - PAGE_SZ) break;
							p += PAGE_SZ;
						end
					end
				end
				default: o.stat = STAT_INVALID;
			endcase
			pending.push_back(o);
		endfunction

		task report_mismatch(input string msg);
			if (mismatches < 40) $display("MISMATCH @%0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(input logic [ADDR_W-1:0] page, input logic [1:0] stat);
			outcome_t o;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected result page %h status %0d", page, stat));
				return;
			end
			o = pending.pop_front();
			checked++;
			stat_seen[o.stat]++;
			if (stat !== o.stat)
				report_mismatch($sformatf("status %0d, predicted %s", stat, o.stat.name()));
			if (page !== o.page)
				report_mismatch($sformatf("page_address %h, predicted %h", page, o.page));
		endtask
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	logic [1:0]          action    = ACT_FREE;
	logic [ADDR_W-1:0]   address   = '0;
	logic [ADDR_W-1:0]   range_end = '0;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [PADDR_W-1:0]  paddr     = '0;
	logic [ADDR_W-1:0]   pwdata    = '0;
	logic                busy;
	logic                done;
	logic [ADDR_W-1:0]   page_address;
	logic [1:0]          status;
	logic [ADDR_W-1:0]   prdata;
	logic                pready;

	page_stack_tracker board = new();
	int unsigned       cycles = 0;
	int unsigned       req_tally [4] = '{0, 0, 0, 0};
	int unsigned       settings_used = 0;

	free_page_stack_allocator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.address      (address),
		.range_end    (range_end),
		.done         (done),
		.page_address (page_address),
		.status       (status),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("free_page_stack_allocator: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) board.check_result(page_address, status);
	end

	function automatic logic [ADDR_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// start stays high across back-to-back transactions
	task automatic issue_request(input action_t act, input logic [ADDR_W-1:0] addr,
			input logic [ADDR_W-1:0] rend);
		start     <= 1'b1;
		action    <= act;
		address   <= addr;
		range_end <= rend;
		do @(posedge clk); while (busy);
		board.note_request(act, addr, rend);
		req_tally[act]++;
	endtask

	task automatic pause_sender(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic settle_block();
		start <= 1'b0;
		while (board.pending.size() != 0 || busy) @(posedge clk);
	endtask

	// writes both limits, then reads them back, as one burst of APB transfers
	task automatic program_limits(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
		reg_idx_t          seq [4];
		logic [ADDR_W-1:0] val [2];
		seq = '{REG_LOW, REG_HIGH, REG_LOW, REG_HIGH};
		val[REG_LOW]  = lo;
		val[REG_HIGH] = hi;
		for (int k = 0; k < 4; k++) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= (k < 2);
			paddr   <= {seq[k], 3'b000};
			pwdata  <= val[seq[k]];
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			if (k < 2) begin
				board.set_limit(seq[k], val[seq[k]]);
			end else if (prdata !== val[seq[k]]) begin
				board.report_mismatch($sformatf("%s reads %h, written %h",
					seq[k].name(), prdata, val[seq[k]]));
			end
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		settings_used++;
	endtask

	task automatic random_request(input int unsigned span);
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] e;
		int unsigned       pick;
		void'(board.align_up(board.low_lim, base));
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			a = base + ADDR_W'($urandom_range(0, span + 2)) * PAGE_SZ;
			if ($urandom_range(0, 9) == 0) a += $urandom_range(1, PAGE_BYTES - 1);
			issue_request(ACT_FREE, a, rand64());
		end else if (pick < 70) begin
			issue_request(ACT_ALLOC, rand64(), rand64());
		end else if (pick < 85) begin
			a = base + ADDR_W'($urandom_range(0, span)) * PAGE_SZ
				- $urandom_range(0, PAGE_BYTES - 1);
			e = a + ADDR_W'($urandom_range(0, 12)) * PAGE_SZ + $urandom_range(0, PAGE_BYTES - 1);
			issue_request(ACT_RANGE, a, e);
		end else begin
			a = rand64();
			e = $urandom_range(0, 1) ? rand64() : a + $urandom_range(0, 20 * PAGE_BYTES);
			issue_request(action_t'($urandom_range(0, 3)), a, e);
		end
	endtask

	// calm: number of leading transactions sent with no gaps
	task automatic run_phase(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi,
			input int unsigned items, input int unsigned calm);
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] room;
		int unsigned       span;
		settle_block();
		program_limits(lo, hi);
		span = 8;
		if (board.align_up(lo, base) && hi > base) begin
			room = (hi - base) / PAGE_SZ;
			span = (room > 48) ? 48 : int'(room);
		end
		for (int i = 0; i < items; i++) begin
			if (i >= calm && $urandom_range(0, 99) < 12) pause_sender($urandom_range(1, 10));
			random_request(span);
		end
	endtask

	initial begin
		logic [ADDR_W-1:0] lo;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset limits: nothing can be freed
		issue_request(ACT_ALLOC, '0, '0);
		issue_request(ACT_FREE, '0, '0);
		issue_request(ACT_RANGE, '0, ADDR_MAX);
		issue_request(ACT_RSVD, ADDR_MAX, ADDR_MAX);

		// unaligned lower limit, small window
		settle_block();
		program_limits(A_LOW, A_HIGH);
		issue_request(ACT_FREE, A_BASE, '0);
		issue_request(ACT_FREE, A_BASE + 1, '0);
		issue_request(ACT_FREE, A_BASE - PAGE_SZ, '0);
		issue_request(ACT_FREE, A_HIGH, '0);
		issue_request(ACT_FREE, A_HIGH - PAGE_SZ, '0);
		repeat (3) issue_request(ACT_ALLOC, '0, '0);
		issue_request(ACT_RANGE, A_BASE - 5, A_BASE + 3 * PAGE_SZ + 100);
		issue_request(ACT_RANGE, A_BASE + 1, A_BASE + PAGE_SZ + 10);
		issue_request(ACT_RANGE, '0, 64'd5);
		issue_request(ACT_RANGE, ADDR_MAX, ADDR_MAX);
		issue_request(ACT_RANGE, A_HIGH - 2 * PAGE_SZ, A_HIGH + 2 * PAGE_SZ);
		issue_request(ACT_RANGE, '0, A_BASE + 2 * PAGE_SZ);

		// whole address space: index beyond the store
		settle_block();
		program_limits('0, ADDR_MAX);
		issue_request(ACT_FREE, ADDR_W'(MAX_PAGES) * PAGE_SZ, '0);
		issue_request(ACT_FREE, ADDR_W'(MAX_PAGES - 1) * PAGE_SZ, '0);
		issue_request(ACT_ALLOC, '0, '0);
		issue_request(ACT_FREE, TOP_PAGE, '0);

		// no page boundary above the lower limit
		settle_block();
		program_limits(ADDR_MAX, ADDR_MAX);
		issue_request(ACT_FREE, TOP_PAGE, '0);
		issue_request(ACT_RANGE, '0, ADDR_MAX);

		// single top page; range walk ends at the top of the address space
		settle_block();
		program_limits(TOP_PAGE, ADDR_MAX);
		issue_request(ACT_RANGE, TOP_PAGE, ADDR_MAX);
		issue_request(ACT_ALLOC, '0, '0);

		lo = rand64();
		run_phase(lo, lo + ADDR_W'($urandom_range(8, 48)) * PAGE_SZ + $urandom_range(0, 4095),
			150, 0);
		run_phase('0, ADDR_MAX, 150, 100);
		run_phase(rand64(), rand64(), 120, 0);
		lo = TOP_PAGE - ADDR_W'($urandom_range(0, 40)) * PAGE_SZ - $urandom_range(0, 4095);
		run_phase(lo, ADDR_MAX, 150, 0);
		lo = ADDR_W'($urandom);
		run_phase(lo, lo + ADDR_W'($urandom_range(1, 30)) * PAGE_SZ, 180, 0);

		// fill the store to capacity, then overflow it
		settle_block();
		program_limits(FILL_LOW, ADDR_MAX);
		issue_request(ACT_RANGE, FILL_BASE, FILL_BASE + ADDR_W'(MAX_PAGES + 2) * PAGE_SZ);
		issue_request(ACT_FREE, FILL_BASE, '0);
		issue_request(ACT_RANGE, FILL_BASE, FILL_BASE + 2 * PAGE_SZ);
		repeat (3) issue_request(ACT_ALLOC, '0, '0);
		issue_request(ACT_FREE, FILL_BASE + 5 * PAGE_SZ, '0);

		settle_block();
		repeat (16) @(posedge clk);
		$display("%0d transactions (free %0d, allocate %0d, range %0d, reserved %0d), %0d limit settings",
			req_tally[ACT_FREE] + req_tally[ACT_ALLOC] + req_tally[ACT_RANGE] + req_tally[ACT_RSVD],
			req_tally[ACT_FREE], req_tally[ACT_ALLOC], req_tally[ACT_RANGE],
			req_tally[ACT_RSVD], settings_used);
		$display("%0d results checked (ok %0d, empty %0d, invalid %0d, full %0d), peak depth %0d",
			board.checked, board.stat_seen[STAT_OK], board.stat_seen[STAT_EMPTY],
			board.stat_seen[STAT_INVALID], board.stat_seen[STAT_FULL], board.peak_depth);
		if (board.mismatches == 0) begin
			$display("free_page_stack_allocator: match");
		end else begin
			$display("free_page_stack_allocator: mismatch");
		end
		$finish;
	end

endmodule
